// ----- design/dsr_pkg.sv -----
package dsr_pkg;

    localparam int unsigned RATE_W  = 12;
    localparam int unsigned MAXS_W  = 15;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned TICK_W  = 4;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned DATA_W  = 16;

    localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FWD      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REV      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOP_FWD = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOP_REV = 3'd4;

    localparam logic [IDX_W-1:0] REG_ACCEL_RATE     = 3'd0;
    localparam logic [IDX_W-1:0] REG_BRAKE_RATE     = 3'd1;
    localparam logic [IDX_W-1:0] REG_COAST_RATE     = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_SPEED      = 3'd3;
    localparam logic [IDX_W-1:0] REG_STOP_DELAY_FWD = 3'd4;
    localparam logic [IDX_W-1:0] REG_STOP_DELAY_REV = 3'd5;

    localparam logic [RATE_W-1:0]  ACCEL_RATE_RST     = 12'd64;
    localparam logic [RATE_W-1:0]  BRAKE_RATE_RST     = 12'd128;
    localparam logic [RATE_W-1:0]  COAST_RATE_RST     = 12'd32;
    localparam logic [MAXS_W-1:0]  MAX_SPEED_RST      = 15'd16384;
    localparam logic [DELAY_W-1:0] STOP_DELAY_FWD_RST = 16'd500;
    localparam logic [DELAY_W-1:0] STOP_DELAY_REV_RST = 16'd500;

    typedef struct packed {
        logic              accel_pressed;
        logic              brake_pressed;
        logic [TICK_W-1:0] tick_time;
    } in_item_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic [MODE_W-1:0]         mode;
    } out_item_t;

    typedef struct packed {
        logic [RATE_W-1:0]  accel_rate;
        logic [RATE_W-1:0]  brake_rate;
        logic [RATE_W-1:0]  coast_rate;
        logic [MAXS_W-1:0]  max_speed;
        logic [DELAY_W-1:0] stop_delay_fwd;
        logic [DELAY_W-1:0] stop_delay_rev;
    } cfg_t;

endpackage

// ----- design/dsr_cfg.sv -----
module dsr_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [dsr_pkg::IDX_W-1:0]  cfg_index,
    input  logic [dsr_pkg::DATA_W-1:0] cfg_data,
    output dsr_pkg::cfg_t              cfg
);

    dsr_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_rate     <= dsr_pkg::ACCEL_RATE_RST;
            cfg_reg.brake_rate     <= dsr_pkg::BRAKE_RATE_RST;
            cfg_reg.coast_rate     <= dsr_pkg::COAST_RATE_RST;
            cfg_reg.max_speed      <= dsr_pkg::MAX_SPEED_RST;
            cfg_reg.stop_delay_fwd <= dsr_pkg::STOP_DELAY_FWD_RST;
            cfg_reg.stop_delay_rev <= dsr_pkg::STOP_DELAY_REV_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dsr_pkg::REG_ACCEL_RATE:
                    cfg_reg.accel_rate <= cfg_data[dsr_pkg::RATE_W-1:0];
                dsr_pkg::REG_BRAKE_RATE:
                    cfg_reg.brake_rate <= cfg_data[dsr_pkg::RATE_W-1:0];
                dsr_pkg::REG_COAST_RATE:
                    cfg_reg.coast_rate <= cfg_data[dsr_pkg::RATE_W-1:0];
                dsr_pkg::REG_MAX_SPEED:
                    cfg_reg.max_speed <= cfg_data[dsr_pkg::MAXS_W-1:0];
                dsr_pkg::REG_STOP_DELAY_FWD:
                    cfg_reg.stop_delay_fwd <= cfg_data[dsr_pkg::DELAY_W-1:0];
                dsr_pkg::REG_STOP_DELAY_REV:
                    cfg_reg.stop_delay_rev <= cfg_data[dsr_pkg::DELAY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/dsr_core.sv -----
module dsr_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  dsr_pkg::in_item_t  item,
    input  dsr_pkg::cfg_t      cfg,
    output dsr_pkg::out_item_t res
);

    localparam int unsigned VW = dsr_pkg::SPEED_W + 2;

    typedef enum logic [dsr_pkg::MODE_W-1:0] {
        ST_IDLE     = dsr_pkg::MODE_IDLE,
        ST_FWD      = dsr_pkg::MODE_FWD,
        ST_REV      = dsr_pkg::MODE_REV,
        ST_STOP_FWD = dsr_pkg::MODE_STOP_FWD,
        ST_STOP_REV = dsr_pkg::MODE_STOP_REV
    } state_t;

    state_t                            state_reg, state_next;
    logic signed [dsr_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic [dsr_pkg::DELAY_W-1:0]        timer_reg, timer_next;

    logic [dsr_pkg::RATE_W-1:0]  rate_sel;
    logic [dsr_pkg::SPEED_W-1:0] prod;
    logic [dsr_pkg::MAXS_W-1:0]  start_mag;
    logic signed [VW-1:0]        spd_ext, prod_ext, vmax_ext, v_fwd, v_rev;
    logic signed [VW-1:0]        clamp_fwd, clamp_rev;
    logic                        acc, brk, done;
    logic [dsr_pkg::TICK_W-1:0]  dt;

    assign acc = item.accel_pressed;
    assign brk = item.brake_pressed;
    assign dt  = item.tick_time;

    always_comb
    begin
        case (state_reg)
            ST_FWD:  rate_sel = brk ? cfg.brake_rate : (acc ? cfg.accel_rate : cfg.coast_rate);
            ST_REV:  rate_sel = acc ? cfg.brake_rate : (brk ? cfg.accel_rate : cfg.coast_rate);
            default: rate_sel = cfg.accel_rate;
        endcase
    end

    assign prod      = dsr_pkg::SPEED_W'(rate_sel) * dsr_pkg::SPEED_W'(dt);
    assign start_mag = (prod > dsr_pkg::SPEED_W'(cfg.max_speed)) ? cfg.max_speed
                                                                 : prod[dsr_pkg::MAXS_W-1:0];

    assign spd_ext  = VW'(speed_reg);
    assign prod_ext = signed'(VW'(prod));
    assign vmax_ext = signed'(VW'(cfg.max_speed));

    assign v_fwd = (brk || !acc) ? spd_ext - prod_ext : spd_ext + prod_ext;
    assign v_rev = (acc || !brk) ? spd_ext + prod_ext : spd_ext - prod_ext;

    always_comb
    begin
        if (v_fwd < 0)
            clamp_fwd = '0;
        else if (v_fwd > vmax_ext)
            clamp_fwd = vmax_ext;
        else
            clamp_fwd = v_fwd;

        if (v_rev < -vmax_ext)
            clamp_rev = -vmax_ext;
        else if (v_rev > 0)
            clamp_rev = '0;
        else
            clamp_rev = v_rev;
    end

    assign done = timer_reg <= dsr_pkg::DELAY_W'(dt);

    always_comb
    begin
        state_next = state_reg;
        speed_next = speed_reg;
        timer_next = timer_reg;
        case (state_reg)
            ST_FWD:
            begin
                speed_next = clamp_fwd[dsr_pkg::SPEED_W-1:0];
                if (clamp_fwd == 0)
                begin
                    timer_next = cfg.stop_delay_fwd;
                    state_next = ST_STOP_FWD;
                end
            end
            ST_REV:
            begin
                speed_next = clamp_rev[dsr_pkg::SPEED_W-1:0];
                if (clamp_rev == 0)
                begin
                    timer_next = cfg.stop_delay_rev;
                    state_next = ST_STOP_REV;
                end
            end
            ST_STOP_FWD, ST_STOP_REV:
            begin
                if ((state_reg == ST_STOP_FWD) && acc)
                begin
                    speed_next = signed'(dsr_pkg::SPEED_W'(start_mag));
                    state_next = ST_FWD;
                end
                else if ((state_reg == ST_STOP_REV) && brk)
                begin
                    speed_next = -signed'(dsr_pkg::SPEED_W'(start_mag));
                    state_next = ST_REV;
                end
                else
                begin
                    timer_next = done ? '0 : timer_reg - dsr_pkg::DELAY_W'(dt);
                    if (done)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                if (acc)
                begin
                    speed_next = signed'(dsr_pkg::SPEED_W'(start_mag));
                    state_next = ST_FWD;
                end
                else if (brk)
                begin
                    speed_next = -signed'(dsr_pkg::SPEED_W'(start_mag));
                    state_next = ST_REV;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            speed_reg <= '0;
            timer_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            speed_reg <= speed_next;
            timer_reg <= timer_next;
        end
    end

    assign res.speed = speed_next;
    assign res.mode  = state_next;

endmodule

// ----- design/drive_speed_ramp_fsm.sv -----
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_data  (accel, brake, tick_time)
// out     | output    | out_valid / out_ready | out_data (speed, mode)
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// one item per cycle sustained while the output is not stalled; an accepted item
// goes through the input register, then the state update and result register
// rst_n clears state to idle with zero speed and timer, and loads register defaults
// a stalled output holds its result; the input register stays full and in_ready
// drops until the result register frees up
module drive_speed_ramp_fsm (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  dsr_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output dsr_pkg::out_item_t         out_data,
    input  logic                       cfg_we,
    input  logic [dsr_pkg::IDX_W-1:0]  cfg_index,
    input  logic [dsr_pkg::DATA_W-1:0] cfg_data
);

    dsr_pkg::cfg_t      cfg;
    dsr_pkg::in_item_t  in_item_reg;
    dsr_pkg::out_item_t out_item_reg;
    dsr_pkg::out_item_t res;
    logic               in_vld_reg, out_vld_reg;
    logic               step;

    assign step     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || step;

    dsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dsr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (step)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
        if (step)
            out_item_reg <= res;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

endmodule

// ----- design/dsr_checker.sv -----
module dsr_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input dsr_pkg::out_item_t         out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.mode == dsr_pkg::MODE_IDLE ||
                      out_data.mode == dsr_pkg::MODE_STOP_FWD ||
                      out_data.mode == dsr_pkg::MODE_STOP_REV) |-> out_data.speed == 0)
        else $error("nonzero speed while idle or stopped");

    a_fwd_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.mode == dsr_pkg::MODE_FWD |-> !out_data.speed[15])
        else $error("negative speed in forward");

    a_rev_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.mode == dsr_pkg::MODE_REV |-> out_data.speed[15] ||
                                                            out_data.speed == 0)
        else $error("positive speed in reverse");

    a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && $past(out_valid && !out_ready) &&
        $past(in_valid && in_ready) |-> !in_ready)
        else $error("item taken with no room downstream");

endmodule

bind drive_speed_ramp_fsm dsr_checker u_dsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
